### src/acpi_tsp_pkg.sv
// Shared types, signature codes and header offsets for the ACPI table parser.
// No dependencies; every module of the parser imports this package.
package acpi_tsp_pkg;

  localparam int unsigned MAX_TABLE_BYTES_DEF = 1048576;

  // table_kind codes
  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_FACP  = 3'd1;
  localparam logic [2:0] KIND_OEM0  = 3'd2;
  localparam logic [2:0] KIND_WAET  = 3'd3;
  localparam logic [2:0] KIND_APIC  = 3'd4;
  localparam logic [2:0] KIND_SRAT  = 3'd5;
  localparam logic [2:0] KIND_BGRT  = 3'd6;

  // signatures as little-endian words of bytes 0..3
  localparam logic [31:0] SIG_FACP = 32'h5043_4146;
  localparam logic [31:0] SIG_OEM0 = 32'h304D_454F;
  localparam logic [31:0] SIG_WAET = 32'h5445_4157;
  localparam logic [31:0] SIG_APIC = 32'h4349_5041;
  localparam logic [31:0] SIG_SRAT = 32'h5441_5253;
  localparam logic [31:0] SIG_BGRT = 32'h5452_4742;

  // header byte offsets
  localparam logic [31:0] OFS_SIG_LAST  = 32'd3;
  localparam logic [31:0] OFS_LEN_FIRST = 32'd4;
  localparam logic [31:0] OFS_LEN_LAST  = 32'd7;
  localparam logic [31:0] HDR_BYTES     = 32'd8;
  localparam logic [31:0] OFS_LAPIC_LO  = 32'd36;
  localparam logic [31:0] OFS_LAPIC_HI  = 32'd39;
  localparam logic [31:0] OFS_DSDT_LO   = 32'd40;
  localparam logic [31:0] OFS_DSDT_HI   = 32'd43;
  localparam logic [31:0] OFS_PROFILE   = 32'd45;
  localparam logic [31:0] OFS_SCI_LO    = 32'd46;
  localparam logic [31:0] OFS_SCI_HI    = 32'd47;
  localparam logic [31:0] OFS_XDSDT_LO  = 32'd140;
  localparam logic [31:0] OFS_XDSDT_HI  = 32'd147;
  localparam logic [31:0] MADT_ENTRY_BASE = 32'd44;

  // minimum lengths for FACP fields
  localparam logic [31:0] FACP_MIN_LEN   = 32'd116;
  localparam logic [31:0] FACP_X_MIN_LEN = 32'd148;

  // MADT entry types
  localparam logic [7:0] ENT_LAPIC    = 8'd0;
  localparam logic [7:0] ENT_IOAPIC   = 8'd1;
  localparam logic [7:0] ENT_OVERRIDE = 8'd2;
  localparam logic [7:0] ENT_X2APIC   = 8'd9;

  // counter slots
  localparam int unsigned NUM_COUNTS = 5;
  localparam logic [2:0] CNT_LAPIC    = 3'd0;
  localparam logic [2:0] CNT_IOAPIC   = 3'd1;
  localparam logic [2:0] CNT_OVERRIDE = 3'd2;
  localparam logic [2:0] CNT_X2APIC   = 3'd3;
  localparam logic [2:0] CNT_MISC     = 3'd4;

  typedef logic [15:0] count_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  table_kind;
    logic        sum_good;
    logic [31:0] table_size;
    logic [63:0] first_detail;
    logic [63:0] second_detail;
    logic [15:0] sci_vector;
    logic [7:0]  power_profile;
    logic [15:0] lapic_entries;
    logic [15:0] ioapic_entries;
    logic [15:0] override_entries;
    logic [15:0] x2apic_entries;
    logic [15:0] misc_entries;
  } result_t;

  function automatic logic [2:0] kind_of(input logic [31:0] sig);
    logic [2:0] k;
    k = KIND_OTHER;
    if (sig == SIG_FACP) k = KIND_FACP;
    else if (sig == SIG_OEM0) k = KIND_OEM0;
    else if (sig == SIG_WAET) k = KIND_WAET;
    else if (sig == SIG_APIC) k = KIND_APIC;
    else if (sig == SIG_SRAT) k = KIND_SRAT;
    else if (sig == SIG_BGRT) k = KIND_BGRT;
    return k;
  endfunction

  function automatic logic [2:0] slot_of(input logic [7:0] etype);
    logic [2:0] s;
    case (etype)
      ENT_LAPIC:    s = CNT_LAPIC;
      ENT_IOAPIC:   s = CNT_IOAPIC;
      ENT_OVERRIDE: s = CNT_OVERRIDE;
      ENT_X2APIC:   s = CNT_X2APIC;
      default:      s = CNT_MISC;
    endcase
    return s;
  endfunction

endpackage

### src/acpi_table_stream_parser_core.sv
// Top level of the streaming ACPI description table parser.
// Depends on acpi_tsp_pkg, acpi_tsp_parse and acpi_tsp_out_reg.
//
//  channel | signals                          | beat carries
//  --------+----------------------------------+-------------------------------
//  item    | item_valid, item_ready, item_data | one table byte + first flag
//  res     | res_valid, res_ready, res_data    | one parsed-table summary
//
// One table byte per cycle, sustained while no finished summary waits for
// the result register. A byte lands in the input register on the edge it is
// taken; when it steps, the parser state advances and, on the table's last
// byte, the summary loads the result register, which raises res_valid.
// Reset drops both valid flags and the in-table flag; bytes without a
// preceding first-byte beat are dropped.
// While a summary waits in the result register, bytes that produce no
// summary still flow; only a second summary holds the input register.
module acpi_table_stream_parser_core #(
  parameter int unsigned MAX_TABLE_BYTES = acpi_tsp_pkg::MAX_TABLE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  acpi_tsp_pkg::in_beat_t item_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output acpi_tsp_pkg::result_t res_data
);
  import acpi_tsp_pkg::*;

  // input register
  logic     in_full;
  in_beat_t in_beat;

  logic     step;
  logic     done;
  logic     load;
  logic     space;
  result_t  parse_res;

  // the held byte moves on unless it finishes a table and the result
  // register is still occupied
  assign step       = in_full && (space || !done);
  assign item_ready = !in_full || step;
  assign load       = step && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_beat <= item_data;
    end
  end

  // done depends only on the held byte and table state, not on step;
  // the summary loads only when the held byte actually steps
  acpi_tsp_parse #(
    .MAX_TABLE_BYTES(MAX_TABLE_BYTES)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .beat (in_beat),
    .done (done),
    .res  (parse_res)
  );

  acpi_tsp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_data (parse_res),
    .space     (space),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

### src/acpi_tsp_parse.sv
// Per-byte table state and the combinational update that also forms the result.
// Depends on acpi_tsp_pkg.
module acpi_tsp_parse #(
  parameter int unsigned MAX_TABLE_BYTES = acpi_tsp_pkg::MAX_TABLE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  acpi_tsp_pkg::in_beat_t beat,
  output logic                  done,
  output acpi_tsp_pkg::result_t res
);
  import acpi_tsp_pkg::*;

  localparam logic [31:0] MaxLen = 32'(MAX_TABLE_BYTES);

  logic        parsing;
  logic [31:0] byte_count;
  logic [23:0] sig_low;
  logic [2:0]  kind;
  logic [31:0] length_word;
  logic [7:0]  running_sum;
  logic [7:0]  psum [6];
  logic [31:0] detail_low;
  logic [63:0] detail_high;
  logic [15:0] sci_reg;
  logic [7:0]  profile_reg;
  logic [31:0] next_entry_offset;
  logic [7:0]  entry_type_latch;
  logic        walk_halted;
  count_t      type_counts [NUM_COUNTS];

  logic        hit;
  logic        active;
  logic [7:0]  b;
  logic [31:0] o;
  logic [32:0] count;
  logic [31:0] len_cur;
  logic [7:0]  sum_base;
  logic [7:0]  hdr_sum;
  logic        sum_ok;

  logic [23:0] sig_low_next;
  logic [2:0]  kind_next;
  logic [31:0] length_word_next;
  logic [7:0]  running_sum_next;
  logic [31:0] detail_low_next;
  logic [63:0] detail_high_next;
  logic [15:0] sci_reg_next;
  logic [7:0]  profile_reg_next;
  logic [31:0] next_entry_offset_next;
  logic [7:0]  entry_type_latch_next;
  logic        walk_halted_next;
  count_t      type_counts_next [NUM_COUNTS];

  logic        walk_on;
  logic [32:0] entry_end;
  logic [2:0]  slot;

  always_comb begin
    b      = beat.data_byte;
    hit    = beat.first_byte || parsing;
    active = step && hit;
    o      = beat.first_byte ? '0 : byte_count;
    count  = {1'b0, o} + 33'd1;

    sum_base         = beat.first_byte ? 8'd0 : running_sum;
    running_sum_next = sum_base + b;

    sig_low_next          = sig_low;
    kind_next             = kind;
    length_word_next      = length_word;
    detail_low_next       = detail_low;
    detail_high_next      = detail_high;
    sci_reg_next          = sci_reg;
    profile_reg_next      = profile_reg;
    entry_type_latch_next = entry_type_latch;
    next_entry_offset_next = beat.first_byte ? MADT_ENTRY_BASE : next_entry_offset;
    walk_halted_next      = beat.first_byte ? 1'b0 : walk_halted;
    for (int i = 0; i < NUM_COUNTS; i++) begin
      type_counts_next[i] = beat.first_byte ? '0 : type_counts[i];
    end

    // header capture
    if (o < OFS_SIG_LAST) begin
      sig_low_next[8*o[1:0] +: 8] = b;
    end
    if (o == OFS_SIG_LAST) begin
      kind_next = kind_of({b, sig_low});
    end
    if (o >= OFS_LEN_FIRST && o <= OFS_LEN_LAST) begin
      length_word_next[8*o[1:0] +: 8] = b;
    end
    len_cur = (o == OFS_LEN_LAST) ? {b, length_word[23:0]} : length_word;

    // body fields, kind is settled by now
    walk_on   = 1'b0;
    entry_end = {1'b0, next_entry_offset_next} + {25'd0, b};
    slot      = slot_of(entry_type_latch);
    if (o >= HDR_BYTES && kind == KIND_FACP) begin
      if (o >= OFS_DSDT_LO && o <= OFS_DSDT_HI) begin
        detail_low_next[8*o[1:0] +: 8] = b;
      end else if (o == OFS_PROFILE) begin
        profile_reg_next = b;
      end else if (o == OFS_SCI_LO || o == OFS_SCI_HI) begin
        sci_reg_next[8*o[0] +: 8] = b;
      end else if (o >= OFS_XDSDT_LO && o <= OFS_XDSDT_HI) begin
        // offsets 140..147 land in bytes 0..7
        detail_high_next[8*3'(o[2:0] + 3'd4) +: 8] = b;
      end
    end else if (o >= HDR_BYTES && kind == KIND_APIC) begin
      if (o >= OFS_LAPIC_LO && o <= OFS_LAPIC_HI) begin
        detail_low_next[8*o[1:0] +: 8] = b;
      end else if (o >= OFS_DSDT_LO && o <= OFS_DSDT_HI) begin
        detail_high_next[8*o[1:0] +: 8] = b;
      end else if (o >= MADT_ENTRY_BASE && !walk_halted_next) begin
        walk_on = 1'b1;
      end
    end

    // MADT entry walk: type byte, then length byte
    if (walk_on) begin
      if (o == next_entry_offset_next) begin
        if ({1'b0, o} + 33'd2 > {1'b0, length_word}) begin
          walk_halted_next = 1'b1;
        end else begin
          entry_type_latch_next = b;
        end
      end else if ({1'b0, o} == {1'b0, next_entry_offset_next} + 33'd1) begin
        if (b < 8'd2 || entry_end > {1'b0, length_word}) begin
          walk_halted_next = 1'b1;
        end else begin
          if (type_counts_next[slot] != 16'hFFFF) begin
            type_counts_next[slot] = type_counts_next[slot] + 16'd1;
          end
          next_entry_offset_next = entry_end[31:0];
        end
      end
    end

    // short tables: sum covers only the first len_cur header bytes
    case (len_cur[2:0])
      3'd0:    hdr_sum = 8'd0;
      3'd7:    hdr_sum = sum_base;
      default: hdr_sum = psum[len_cur[2:0] - 3'd1];
    endcase
    sum_ok = (len_cur < HDR_BYTES) ? (hdr_sum == 8'd0) : (running_sum_next == 8'd0);

    // held byte would finish its table; independent of step
    done = hit && (count >= 33'd8) && (count >= {1'b0, len_cur});

    res                  = '0;
    res.table_kind       = kind;
    res.sum_good         = sum_ok && (len_cur != 32'd0) && (len_cur <= MaxLen);
    res.table_size       = len_cur;
    if (kind == KIND_FACP) begin
      if (len_cur >= FACP_MIN_LEN) begin
        res.first_detail  = {32'd0, detail_low_next};
        res.sci_vector    = sci_reg_next;
        res.power_profile = profile_reg_next;
      end
      if (len_cur >= FACP_X_MIN_LEN) begin
        res.second_detail = detail_high_next;
      end
    end else if (kind == KIND_APIC && len_cur >= MADT_ENTRY_BASE) begin
      res.first_detail     = {32'd0, detail_low_next};
      res.second_detail    = {32'd0, detail_high_next[31:0]};
      res.lapic_entries    = type_counts_next[CNT_LAPIC];
      res.ioapic_entries   = type_counts_next[CNT_IOAPIC];
      res.override_entries = type_counts_next[CNT_OVERRIDE];
      res.x2apic_entries   = type_counts_next[CNT_X2APIC];
      res.misc_entries     = type_counts_next[CNT_MISC];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parsing           <= 1'b0;
      byte_count        <= '0;
      walk_halted       <= 1'b0;
      next_entry_offset <= MADT_ENTRY_BASE;
      for (int i = 0; i < NUM_COUNTS; i++) begin
        type_counts[i] <= '0;
      end
    end else if (active) begin
      parsing           <= !done;
      byte_count        <= count[31:0];
      walk_halted       <= walk_halted_next;
      next_entry_offset <= next_entry_offset_next;
      for (int i = 0; i < NUM_COUNTS; i++) begin
        type_counts[i] <= type_counts_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      sig_low          <= sig_low_next;
      kind             <= kind_next;
      length_word      <= length_word_next;
      running_sum      <= running_sum_next;
      detail_low       <= detail_low_next;
      detail_high      <= detail_high_next;
      sci_reg          <= sci_reg_next;
      profile_reg      <= profile_reg_next;
      entry_type_latch <= entry_type_latch_next;
      for (int k = 0; k < 6; k++) begin
        if (o == 32'(k)) begin
          psum[k] <= running_sum_next;
        end
      end
    end
  end

endmodule

### src/acpi_tsp_out_reg.sv
// Result register with valid/ready toward the consumer.
// Depends on acpi_tsp_pkg.
module acpi_tsp_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  acpi_tsp_pkg::result_t load_data,
  output logic                 space,
  output logic                 res_valid,
  input  logic                 res_ready,
  output acpi_tsp_pkg::result_t res_data
);
  import acpi_tsp_pkg::*;

  assign space = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (space) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      res_data <= load_data;
    end
  end

endmodule
